### rtl/amp_pkg.sv
// Shared types and constants of the audio mux preset controller.
package amp_pkg;

  // Command codes carried in the cmd field
  localparam logic [2:0] CMD_ROUTE    = 3'd0;
  localparam logic [2:0] CMD_SAVE_DEF = 3'd1;
  localparam logic [2:0] CMD_ARM      = 3'd2;
  localparam logic [2:0] CMD_DELETE   = 3'd3;
  localparam logic [2:0] CMD_IR       = 3'd4;
  localparam logic [2:0] CMD_TICK     = 3'd5;

  // Default selector values for save default
  localparam logic [4:0] DEF_USB  = 5'd0;
  localparam logic [4:0] DEF_JACK = 5'd1;

  localparam int OUTPUTS     = 4;
  localparam int SEL_W       = 3;
  localparam int ROUTE_W     = OUTPUTS * SEL_W;
  localparam int KEY_W       = 56;
  localparam int ENTRY_W     = KEY_W + ROUTE_W;
  localparam int DELAY_W     = 24;
  localparam int HIT_W       = 5;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  // Write-back delay after reset: two minutes of 1 ms ticks
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(1000 * 60 * 2);

  // Input item, cmd in the lowest bits
  typedef struct packed {
    logic [1:0]  pad;
    logic [31:0] ir_code;
    logic [15:0] ir_address;
    logic [7:0]  ir_protocol;
    logic [4:0]  slot;
    logic [2:0]  input_sel;
    logic [2:0]  output_sel;
    logic [2:0]  cmd;
  } item_t;

  // Result item, status in the lowest bits
  typedef struct packed {
    logic [4:0]       pad;
    logic             commit;
    logic [HIT_W-1:0] hit_slot;
    logic [2:0]       route_four;
    logic [2:0]       route_three;
    logic [2:0]       route_two;
    logic [2:0]       route_one;
    logic             status;
  } result_t;

  // Preset memory access controls
  typedef struct packed {
    logic               we;
    logic               re;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

endpackage

### rtl/amp_preset_mem.sv
// Preset table memory: one write and one registered read port, per-entry valid bits.
module amp_preset_mem #(
  parameter int SLOTS = 16,
  parameter int AW    = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  amp_pkg::mem_req_t            req,
  input  logic [AW-1:0]                wr_addr,
  input  logic [AW-1:0]                rd_addr,
  output logic [amp_pkg::ENTRY_W-1:0]  rdata
);

  logic [amp_pkg::ENTRY_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]            valid_r;
  logic [amp_pkg::ENTRY_W-1:0] rdata_r;
  logic                        rvld_r;

  // Mark written entries; reset leaves every entry reading as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[wr_addr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else if (req.re) begin
      rvld_r <= valid_r[rd_addr];
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

### rtl/amp_ctrl.sv
// Command sequencer: routing, learn arm, countdown and the preset match scan.
module amp_ctrl #(
  parameter int SLOTS   = 16,
  parameter int SOURCES = 4,
  parameter int AW      = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  amp_pkg::item_t                item,
  input  logic [amp_pkg::DELAY_W-1:0]   write_delay,
  output logic                          res_valid,
  input  logic                          res_ready,
  output amp_pkg::result_t              res,
  output amp_pkg::mem_req_t             mem_req,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic [amp_pkg::ENTRY_W-1:0]   mem_rdata
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOTS);
  localparam logic [AW-1:0]    LAST_IDX = AW'(SLOTS - 1);
  localparam logic [6:0]       SLOT_MAX = 7'(SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [2:0]                    route_r [amp_pkg::OUTPUTS];
  logic [2:0]                    route_nxt [amp_pkg::OUTPUTS];
  logic [4:0]                    armed_r, armed_nxt;
  logic [amp_pkg::DELAY_W-1:0]   timer_r, timer_nxt;
  logic [amp_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [CNT_W-1:0]              issue_r, issue_nxt;
  logic                          cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]                 cmp_idx_r, cmp_idx_nxt;
  logic                          status_r, status_nxt;
  logic [amp_pkg::HIT_W-1:0]     hit_r, hit_nxt;
  logic                          commit_r, commit_nxt;

  logic                          accept;
  logic [amp_pkg::KEY_W-1:0]     item_key;
  logic                          slot_ok;
  logic                          armed_ok;
  logic [AW-1:0]                 slot_addr;
  logic [AW-1:0]                 armed_addr;
  logic [amp_pkg::ROUTE_W-1:0]   route_packed;
  logic                          issuing;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_DONE);

  assign item_key     = {item.ir_protocol, item.ir_address, item.ir_code};
  assign slot_ok      = (item.slot != 5'd0) && ({2'b00, item.slot} <= SLOT_MAX);
  assign armed_ok     = (armed_r != 5'd0) && ({2'b00, armed_r} <= SLOT_MAX);
  assign slot_addr    = AW'(7'(item.slot) - 7'd1);
  assign armed_addr   = AW'(7'(armed_r) - 7'd1);
  assign route_packed = {route_r[3], route_r[2], route_r[1], route_r[0]};
  assign issuing      = (state_r == ST_SCAN) && (issue_r != CNT_END);

  // Sequence one item: decode on accept, walk the table for an IR match
  always_comb begin
    state_nxt   = state_r;
    route_nxt   = route_r;
    armed_nxt   = armed_r;
    timer_nxt   = timer_r;
    key_nxt     = key_r;
    issue_nxt   = issue_r;
    cmp_vld_nxt = issuing;
    cmp_idx_nxt = AW'(issue_r);
    status_nxt  = status_r;
    hit_nxt     = hit_r;
    commit_nxt  = commit_r;
    mem_req     = '0;
    mem_wr_addr = slot_addr;
    mem_rd_addr = AW'(issue_r);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt = 1'b0;
          hit_nxt    = '0;
          commit_nxt = 1'b0;
          state_nxt  = ST_DONE;
          unique case (item.cmd)
            amp_pkg::CMD_ROUTE: begin
              if (item.output_sel != 3'd0 &&
                  item.output_sel <= 3'(amp_pkg::OUTPUTS) &&
                  item.input_sel <= 3'(SOURCES)) begin
                route_nxt[2'(item.output_sel - 3'd1)] = item.input_sel;
              end else begin
                status_nxt = 1'b1;
              end
            end
            amp_pkg::CMD_SAVE_DEF: begin
              // Defaults are held off-block; only the countdown is visible here
              if (item.slot == amp_pkg::DEF_USB || item.slot == amp_pkg::DEF_JACK) begin
                timer_nxt = write_delay;
              end else begin
                status_nxt = 1'b1;
              end
            end
            amp_pkg::CMD_ARM: begin
              if (slot_ok) begin
                armed_nxt = item.slot;
              end else begin
                status_nxt = 1'b1;
              end
            end
            amp_pkg::CMD_DELETE: begin
              if (slot_ok) begin
                mem_req.we = 1'b1;
                timer_nxt  = write_delay;
              end else begin
                status_nxt = 1'b1;
              end
            end
            amp_pkg::CMD_IR: begin
              armed_nxt = '0;
              if (armed_ok) begin
                // Learn: store key and current routing in the armed slot
                mem_req.we    = 1'b1;
                mem_req.wdata = {item_key, route_packed};
                mem_wr_addr   = armed_addr;
                timer_nxt     = write_delay;
                hit_nxt       = armed_r;
              end else begin
                key_nxt     = item_key;
                issue_nxt   = '0;
                cmp_vld_nxt = 1'b0;
                state_nxt   = ST_SCAN;
              end
            end
            amp_pkg::CMD_TICK: begin
              if (timer_r != '0) begin
                timer_nxt  = timer_r - 1'b1;
                commit_nxt = (timer_r == amp_pkg::DELAY_W'(1));
              end
            end
            default: begin
              status_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle, compare the entry read the cycle before
        mem_req.re = issuing;
        if (issuing) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (mem_rdata[amp_pkg::ENTRY_W-1:amp_pkg::ROUTE_W] == key_r) begin
            route_nxt[0] = mem_rdata[2:0];
            route_nxt[1] = mem_rdata[5:3];
            route_nxt[2] = mem_rdata[8:6];
            route_nxt[3] = mem_rdata[11:9];
            hit_nxt      = amp_pkg::HIT_W'(7'(cmp_idx_r) + 7'd1);
          end
          if (cmp_idx_r == LAST_IDX) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      route_r   <= '{default: '0};
      armed_r   <= '0;
      timer_r   <= '0;
      issue_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      route_r   <= route_nxt;
      armed_r   <= armed_nxt;
      timer_r   <= timer_nxt;
      issue_r   <= issue_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    status_r  <= status_nxt;
    hit_r     <= hit_nxt;
    commit_r  <= commit_nxt;
  end

  always_comb begin
    res             = '0;
    res.status      = status_r;
    res.route_one   = route_r[0];
    res.route_two   = route_r[1];
    res.route_three = route_r[2];
    res.route_four  = route_r[3];
    res.hit_slot    = hit_r;
    res.commit      = commit_r;
  end

endmodule

### rtl/audio_mux_preset_controller.sv
// Top level of the audio mux preset controller.
// Takes one command item at a time and returns one result item for each. Most
// commands pass from acceptance to a done state and then into the output
// register, and no new item is taken until the last result has left the done
// state; an IR code that does not complete a learn walks the preset table one
// entry per cycle through the memory's single read port before its result
// reaches the done state. The preset table is cleared by reset at once through
// per-entry valid bits, with no clearing pass. The output register lets a
// result wait while the next item is taken. Configuration writes to cfg_data are
// always accepted and should only be made while the block is idle.
module audio_mux_preset_controller #(
  parameter int SLOTS   = 16,
  parameter int SOURCES = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cmd, output_sel, input_sel, slot, ir_protocol, ir_address, ir_code, zero pad
  input  logic [amp_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status, route_one, route_two, route_three, route_four, hit_slot, commit, zero pad
  output logic [amp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [amp_pkg::DELAY_W-1:0]        cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [amp_pkg::DELAY_W-1:0]  write_delay_r;
  amp_pkg::item_t               item;
  amp_pkg::result_t             res;
  logic                         res_valid;
  logic                         res_ready;
  amp_pkg::mem_req_t            mem_req;
  logic [AW-1:0]                mem_wr_addr;
  logic [AW-1:0]                mem_rd_addr;
  logic [amp_pkg::ENTRY_W-1:0]  mem_rdata;
  logic                         out_valid_r;
  logic [amp_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign item = amp_pkg::item_t'(in_tdata);

  // Hold the write-back delay register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_delay_r <= amp_pkg::DELAY_RESET;
    end else if (cfg_valid) begin
      write_delay_r <= cfg_data;
    end
  end

  amp_ctrl #(
    .SLOTS   (SLOTS),
    .SOURCES (SOURCES),
    .AW      (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .item        (item),
    .write_delay (write_delay_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_req     (mem_req),
    .mem_wr_addr (mem_wr_addr),
    .mem_rd_addr (mem_rd_addr),
    .mem_rdata   (mem_rdata)
  );

  amp_preset_mem #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .wr_addr (mem_wr_addr),
    .rd_addr (mem_rd_addr),
    .rdata   (mem_rdata)
  );

  // Output register: load a finished item, drop it once taken
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/amp_checker.sv
// Port-level checks of the audio mux preset controller, bound to the top level.
module amp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [amp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // A waiting result item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // Items are worked one at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is at work");

  // A rejected item neither hits a slot nor commits
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[17:13] == 5'd0 && !out_tdata[18])
    else $error("rejected item reports a hit or commit");

  // A commit comes only from a tick, never with a slot hit
  a_commit_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18] |-> out_tdata[17:13] == 5'd0)
    else $error("commit reported together with a slot hit");

endmodule

bind audio_mux_preset_controller amp_checker u_amp_checker (.*);

### sim/audio_mux_preset_controller_tb.sv
// Self-checking testbench for the audio mux preset controller.
module audio_mux_preset_controller_tb;
  import amp_pkg::*;

  localparam int SLOTS       = 16;
  localparam int SOURCES     = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 24;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 140;
  localparam int POOL_KEYS   = 8;

  // Command codes the block does not define
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  // Tracks mux routing, defaults and the preset table; predicts one result per command
  class mux_scoreboard;
    logic [SEL_W-1:0]   route_now [OUTPUTS];
    logic [SEL_W-1:0]   usb_route [OUTPUTS];
    logic [SEL_W-1:0]   jack_route [OUTPUTS];
    logic [KEY_W-1:0]   slot_key [SLOTS];
    logic [ROUTE_W-1:0] slot_route [SLOTS];
    logic [HIT_W-1:0]   armed;
    logic [DELAY_W-1:0] countdown;
    logic [DELAY_W-1:0] wb_delay;
    result_t            pending_results [$];
    int                 mismatches;
    int                 checked;
    int                 commits;
    int                 hits;

    function void clear();
      for (int i = 0; i < OUTPUTS; i++) begin
        route_now[i]  = '0;
        usb_route[i]  = '0;
        jack_route[i] = '0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i]   = '0;
        slot_route[i] = '0;
      end
      armed       = '0;
      countdown   = '0;
      wb_delay    = DELAY_RESET;
      mismatches  = 0;
      checked     = 0;
      commits     = 0;
      hits        = 0;
      pending_results.delete();
    endfunction

    function void set_delay(logic [DELAY_W-1:0] d);
      wb_delay = d;
    endfunction

    // Apply one accepted command and queue the result it must produce
    function void note_command(item_t it);
      result_t            r;
      logic [KEY_W-1:0]   key;
      logic [ROUTE_W-1:0] packed_route;
      r = '0;
      key = {it.ir_protocol, it.ir_address, it.ir_code};
      for (int i = 0; i < OUTPUTS; i++) packed_route[SEL_W*i +: SEL_W] = route_now[i];
      case (it.cmd)
        CMD_ROUTE: begin
          if (it.output_sel >= 1 && it.output_sel <= OUTPUTS && it.input_sel <= SOURCES)
            route_now[it.output_sel - 1] = it.input_sel;
          else
            r.status = 1'b1;
        end
        CMD_SAVE_DEF: begin
          if (it.slot == DEF_USB) begin
            usb_route = route_now;
            countdown = wb_delay;
          end else if (it.slot == DEF_JACK) begin
            jack_route = route_now;
            countdown = wb_delay;
          end else begin
            r.status = 1'b1;
          end
        end
        CMD_ARM: begin
          if (it.slot >= 1 && it.slot <= SLOTS) armed = it.slot;
          else r.status = 1'b1;
        end
        CMD_DELETE: begin
          if (it.slot >= 1 && it.slot <= SLOTS) begin
            slot_key[it.slot - 1]   = '0;
            slot_route[it.slot - 1] = '0;
            countdown = wb_delay;
          end else begin
            r.status = 1'b1;
          end
        end
        CMD_IR: begin
          if (armed >= 1 && armed <= SLOTS) begin
            // learn: store key and routing in the armed slot, then disarm
            slot_key[armed - 1]   = key;
            slot_route[armed - 1] = packed_route;
            countdown  = wb_delay;
            r.hit_slot = armed;
            armed      = '0;
          end else begin
            // walk every slot in order so the last match wins
            armed = '0;
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_key[i] == key) begin
                for (int o = 0; o < OUTPUTS; o++) route_now[o] = slot_route[i][SEL_W*o +: SEL_W];
                r.hit_slot = HIT_W'(i + 1);
              end
            end
          end
        end
        CMD_TICK: begin
          if (countdown != 0) begin
            countdown = countdown - 1'b1;
            if (countdown == 0) r.commit = 1'b1;
          end
        end
        default: r.status = 1'b1;
      endcase
      r.route_one   = route_now[0];
      r.route_two   = route_now[1];
      r.route_three = route_now[2];
      r.route_four  = route_now[3];
      pending_results.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf("status %0d routes %0d %0d %0d %0d hit %0d commit %0d", r.status,
                       r.route_one, r.route_two, r.route_three, r.route_four, r.hit_slot,
                       r.commit);
    endfunction

    // Compare an accepted result with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      bit      bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      bad = (got.status !== want.status) || (got.route_one !== want.route_one) ||
            (got.route_two !== want.route_two) || (got.route_three !== want.route_three) ||
            (got.route_four !== want.route_four) || (got.hit_slot !== want.hit_slot) ||
            (got.commit !== want.commit);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: expected %s, got %s", checked, show(want),
                   show(got));
      end
      if (got.commit === 1'b1) commits++;
      if (got.hit_slot !== '0) hits++;
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [DELAY_W-1:0]     cfg_data;

  mux_scoreboard    sb;
  logic [KEY_W-1:0] key_pool [POOL_KEYS];
  int               tx_max_gap   = 13;
  int               rx_max_stall = 13;
  int               rx_hold      = 0;
  int               items_sent   = 0;
  int               delays_used  = 1;

  audio_mux_preset_controller #(
    .SLOTS   (SLOTS),
    .SOURCES (SOURCES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Place a 56-bit IR key into the protocol, address and code fields
  function automatic item_t with_key(item_t it, logic [KEY_W-1:0] k);
    it.ir_protocol = k[55:48];
    it.ir_address  = k[47:32];
    it.ir_code     = k[31:0];
    return it;
  endfunction

  function automatic item_t cmd_item(logic [2:0] c, logic [2:0] osel, logic [2:0] isel,
                                     logic [4:0] slot_no, logic [KEY_W-1:0] k);
    item_t it;
    it = '0;
    it.cmd        = c;
    it.output_sel = osel;
    it.input_sel  = isel;
    it.slot       = slot_no;
    return with_key(it, k);
  endfunction

  function automatic item_t random_fill();
    item_t it;
    it.pad         = '0;
    it.cmd         = 3'($urandom_range(0, 7));
    it.output_sel  = 3'($urandom_range(0, 7));
    it.input_sel   = 3'($urandom_range(0, 7));
    it.slot        = 5'($urandom_range(0, 31));
    it.ir_protocol = 8'($urandom_range(0, 255));
    it.ir_address  = 16'($urandom_range(0, 65535));
    it.ir_code     = $urandom;
    return it;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input item_t it);
    int gap;
    gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= it;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_delay_reg(input logic [DELAY_W-1:0] d);
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_delay(d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed commands and learn sequences, with some malformed ones
  task automatic random_command();
    item_t it;
    int    pick;
    it   = random_fill();
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.cmd        = CMD_ROUTE;
      it.output_sel = 3'($urandom_range(1, OUTPUTS));
      it.input_sel  = 3'($urandom_range(0, SOURCES));
    end else if (pick < 25) begin
      it.cmd = CMD_ROUTE;
    end else if (pick < 30) begin
      it.cmd = CMD_SAVE_DEF;
      if ($urandom_range(0, 3) != 0) it.slot = $urandom_range(0, 1) ? DEF_JACK : DEF_USB;
    end else if (pick < 40) begin
      // arm a slot, then let the next code be learnt into it
      it.cmd  = CMD_ARM;
      it.slot = 5'($urandom_range(1, SLOTS));
      send_item(it);
      it     = with_key(random_fill(), key_pool[$urandom_range(0, POOL_KEYS - 1)]);
      it.cmd = CMD_IR;
    end else if (pick < 55) begin
      it     = with_key(it, key_pool[$urandom_range(0, POOL_KEYS - 1)]);
      it.cmd = CMD_IR;
    end else if (pick < 60) begin
      it.cmd = CMD_IR;
    end else if (pick < 65) begin
      it.cmd = CMD_DELETE;
      if ($urandom_range(0, 3) != 0) it.slot = 5'($urandom_range(1, SLOTS));
    end else if (pick < 90) begin
      it.cmd = CMD_TICK;
    end else if (pick < 95) begin
      it.cmd = CMD_ARM;
    end else begin
      it.cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
    end
    send_item(it);
  endtask

  task automatic run_random(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_command();
  endtask

  // Result side: random stalls, with one long hold-off on request
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = (rx_max_stall == 0) ? 0 : $urandom_range(0, rx_max_stall);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(result_t'(out_tdata));
      @(negedge clk);
    end
  end

  // End the run if no handshake happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no handshake for %0d cycles, giving up", quiet);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [DELAY_W-1:0] delay_set [6];
    logic [KEY_W-1:0]   key_b;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    sb = new();
    sb.clear();
    key_pool[0] = '1;
    key_pool[1] = '0;
    for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = KEY_W'({$urandom, $urandom});
    key_b = {8'h01, 16'h0000, 32'h0000_0001};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle tick, selector extremes, defaults, bad indexes, learn and match
    send_item(cmd_item(CMD_TICK, 3'd0, 3'd0, 5'd0, '0));
    send_item(cmd_item(CMD_ROUTE, 3'd1, 3'd4, 5'd0, '0));
    send_item(cmd_item(CMD_ROUTE, 3'd4, 3'd1, 5'd0, '0));
    send_item(cmd_item(CMD_ROUTE, 3'd3, 3'd2, 5'd0, '0));
    send_item(cmd_item(CMD_ROUTE, 3'd0, 3'd3, 5'd0, '0));
    send_item(cmd_item(CMD_ROUTE, 3'd7, 3'd1, 5'd0, '0));
    send_item(cmd_item(CMD_ROUTE, 3'd2, 3'd5, 5'd0, '0));
    send_item(cmd_item(CMD_ROUTE, 3'd2, 3'd7, 5'd0, '0));
    send_item(cmd_item(CMD_SAVE_DEF, 3'd0, 3'd0, DEF_USB, '0));
    send_item(cmd_item(CMD_SAVE_DEF, 3'd0, 3'd0, DEF_JACK, '0));
    send_item(cmd_item(CMD_SAVE_DEF, 3'd0, 3'd0, 5'd2, '0));
    send_item(cmd_item(CMD_ARM, 3'd0, 3'd0, 5'd0, '0));
    send_item(cmd_item(CMD_ARM, 3'd0, 3'd0, 5'd17, '0));
    send_item(cmd_item(CMD_DELETE, 3'd0, 3'd0, 5'd31, '0));
    send_item(cmd_item(CMD_ARM, 3'd0, 3'd0, 5'd1, '0));
    send_item(cmd_item(CMD_IR, 3'd0, 3'd0, 5'd0, '1));
    send_item(cmd_item(CMD_ARM, 3'd0, 3'd0, 5'd16, '0));
    send_item(cmd_item(CMD_IR, 3'd0, 3'd0, 5'd0, key_b));
    // all-zero code hits the empty slots and mutes everything
    send_item(cmd_item(CMD_IR, 3'd0, 3'd0, 5'd0, '0));
    send_item(cmd_item(CMD_IR, 3'd0, 3'd0, 5'd0, '1));
    send_item(cmd_item(CMD_DELETE, 3'd0, 3'd0, 5'd16, '0));
    send_item(cmd_item(CMD_IR, 3'd0, 3'd0, 5'd0, {8'h5A, 16'($urandom), $urandom}));
    send_item(cmd_item(CMD_SPARE6, 3'd0, 3'd0, 5'd0, '0));
    send_item(cmd_item(CMD_SPARE7, 3'd0, 3'd0, 5'd0, '0));
    send_item(cmd_item(CMD_TICK, 3'd0, 3'd0, 5'd0, '0));
    drain();

    // Random phases, each under its own write-back delay
    delay_set[0] = 24'd3;
    delay_set[1] = 24'd1;
    delay_set[2] = 24'd0;
    delay_set[3] = '1;
    delay_set[4] = 24'($urandom_range(2, 40));
    delay_set[5] = 24'd2;
    for (int p = 0; p < 6; p++) begin
      write_delay_reg(delay_set[p]);
      delays_used++;
      tx_max_gap   = (p == 1 || p == 4) ? 0 : 13;
      rx_max_stall = (p == 3 || p == 4) ? 0 : 13;
      if (p == 2) begin
        // hold the result side off while the sender keeps pushing items
        run_random(PHASE_ITEMS / 2);
        rx_hold    = LONG_HOLD;
        tx_max_gap = 0;
        run_random(PHASE_ITEMS / 4);
        tx_max_gap = 13;
        // pause until every result is back, then resume
        in_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        run_random(PHASE_ITEMS / 4);
      end else begin
        run_random(PHASE_ITEMS);
      end
      drain();
    end

    $display("ran %0d commands under %0d write-back delays, %0d results checked",
             items_sent, delays_used, sb.checked);
    $display("saw %0d preset hits and %0d commit requests, %0d mismatches",
             sb.hits, sb.commits, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### audio_mux_preset_controller.f
rtl/amp_pkg.sv
rtl/amp_preset_mem.sv
rtl/amp_ctrl.sv
rtl/audio_mux_preset_controller.sv
rtl/amp_checker.sv
sim/audio_mux_preset_controller_tb.sv
